[design/msr_pkg.sv]
// Shared constants for the minimal-standard generator with hash reseed.
// Used by msr_lcg_step, msr_hash_step and minstd_rng_with_hash_reseed_unit.
`default_nettype none

package msr_pkg;

  // Seed and hash widths.
  localparam int unsigned SEED_W = 31;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned MULT_W = 15;
  localparam int unsigned PROD_W = SEED_W + MULT_W;

  // Generator constants: seed = seed * 16807 mod (2^31 - 1).
  localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
  localparam logic [SEED_W-1:0] LCG_MOD  = 31'h7fff_ffff;

  // Reseed constants.
  localparam int unsigned       HASH_KEEP_W  = 27;
  localparam int unsigned       HASH_BYTES   = 28;
  localparam int unsigned       BYTE_CNT_W   = 5;
  localparam int unsigned       WARMUP_DRAWS = 5;
  localparam int unsigned       WARM_CNT_W   = 3;

  // Command codes.
  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_RESEED = 2'd2;

endpackage

`default_nettype wire

[design/minstd_rng_with_hash_reseed_unit.sv]
// Minimal-standard generator with hash reseed: the sequencer and the seed.
// Depends on msr_pkg, msr_lcg_step and msr_hash_step.
//
// Usage: an item on the input channel (in_valid_i, in_stall_o) carries a
// command and its operands. Each item gives exactly one item on the output
// channel (out_valid_o, out_stall_i): the seed after the command, and
// bad_seed for a load of a seed of zero or below.
// Path from accept to the result in the output register:
//   load, or the unused command: written there straight from idle.
//   draw: a multiply step, then a fold step of the step unit.
//   reseed: 28 byte steps of the hash unit, one closing-mix step,
//   then five draws, each a multiply and a fold on the same step unit.
// One item is in work at a time; the next is taken once the sequencer is
// idle and the output register is empty or being emptied, so a new draw
// is not taken before the last one has reached the output register.
// A stall on the output holds the result and keeps the input stalled.
// Reset sets the seed to 1 and empties the output register.
`default_nettype none

module minstd_rng_with_hash_reseed_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] seed_value_i,
  input  wire logic [31:0] base_id_i,
  input  wire logic [63:0] coord_x_i,
  input  wire logic [63:0] coord_y_i,
  input  wire logic [63:0] coord_z_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [30:0]      sample_o,
  output logic             bad_seed_o
);

  localparam int unsigned SEED_W  = msr_pkg::SEED_W;
  localparam int unsigned BYTES_W = 8 * msr_pkg::HASH_BYTES;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_RED  = 3'd2;
  localparam logic [2:0] ST_HASH = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [msr_pkg::BYTE_CNT_W-1:0] LAST_BYTE =
    msr_pkg::BYTE_CNT_W'(msr_pkg::HASH_BYTES - 1);
  localparam logic [msr_pkg::WARM_CNT_W-1:0] WARM_START =
    msr_pkg::WARM_CNT_W'(msr_pkg::WARMUP_DRAWS - 1);

  logic [2:0]                      state_q, state_d;
  logic [SEED_W-1:0]               seed_q, seed_d;
  logic [msr_pkg::WARM_CNT_W-1:0]  warm_q, warm_d;
  logic [msr_pkg::BYTE_CNT_W-1:0]  byte_cnt_q, byte_cnt_d;
  logic [BYTES_W-1:0]              bytes_q, bytes_d;
  logic [msr_pkg::HASH_W-1:0]      hash_q, hash_d;
  logic                            out_valid_q, out_valid_d;
  logic [SEED_W-1:0]               sample_q, sample_d;
  logic                            bad_q, bad_d;

  logic              in_accept;
  logic              out_take;
  logic              mul_en;
  logic [SEED_W-1:0] lcg_next;
  logic [msr_pkg::HASH_W-1:0] hash_mixed;
  logic [SEED_W-1:0] hash_seed;

  // Handshakes.
  assign out_take   = out_valid_q & ~out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) | (out_valid_q & out_stall_i);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign mul_en     = (state_q == ST_MUL);

  msr_lcg_step u_lcg (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .seed_i   (seed_q),
    .next_o   (lcg_next)
  );

  msr_hash_step u_hash (
    .hash_i  (hash_q),
    .byte_i  (bytes_q[7:0]),
    .mixed_o (hash_mixed),
    .seed_o  (hash_seed)
  );

  // Sequencer: decode the item, run the hash bytes and the draws.
  always_comb begin
    state_d     = state_q;
    seed_d      = seed_q;
    warm_d      = warm_q;
    byte_cnt_d  = byte_cnt_q;
    bytes_d     = bytes_q;
    hash_d      = hash_q;
    out_valid_d = out_take ? 1'b0 : out_valid_q;
    sample_d    = sample_q;
    bad_d       = bad_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (cmd_i)
            msr_pkg::CMD_DRAW: begin
              warm_d  = '0;
              state_d = ST_MUL;
            end
            msr_pkg::CMD_LOAD: begin
              out_valid_d = 1'b1;
              if (seed_value_i == '0 || seed_value_i[31]) begin
                bad_d    = 1'b1;
                sample_d = seed_q;
              end else begin
                bad_d    = 1'b0;
                seed_d   = seed_value_i[SEED_W-1:0];
                sample_d = seed_value_i[SEED_W-1:0];
              end
            end
            msr_pkg::CMD_RESEED: begin
              bytes_d    = {coord_z_i, coord_y_i, coord_x_i, base_id_i};
              hash_d     = '0;
              byte_cnt_d = '0;
              state_d    = ST_HASH;
            end
            default: begin
              out_valid_d = 1'b1;
              bad_d       = 1'b0;
              sample_d    = seed_q;
            end
          endcase
        end
      end
      ST_HASH: begin
        hash_d     = hash_mixed;
        bytes_d    = bytes_q >> 8;
        byte_cnt_d = byte_cnt_q + 1'b1;
        if (byte_cnt_q == LAST_BYTE) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        seed_d  = hash_seed;
        warm_d  = WARM_START;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_RED;
      end
      ST_RED: begin
        seed_d = lcg_next;
        if (warm_q == '0) begin
          out_valid_d = 1'b1;
          bad_d       = 1'b0;
          sample_d    = lcg_next;
          state_d     = ST_IDLE;
        end else begin
          warm_d  = warm_q - 1'b1;
          state_d = ST_MUL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and the seed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= {{(SEED_W - 1){1'b0}}, 1'b1};
      warm_q      <= '0;
      byte_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      warm_q      <= warm_d;
      byte_cnt_q  <= byte_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    bytes_q  <= bytes_d;
    hash_q   <= hash_d;
    sample_q <= sample_d;
    bad_q    <= bad_d;
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign bad_seed_o  = bad_q;

endmodule

`default_nettype wire

[design/msr_lcg_step.sv]
// One generator step: a registered multiply, then a combinational fold.
// Depends on msr_pkg for widths and the generator constants.
`default_nettype none

module msr_lcg_step (
  input  wire logic                      clk_i,
  input  wire logic                      mul_en_i,
  input  wire logic [msr_pkg::SEED_W-1:0] seed_i,
  output logic      [msr_pkg::SEED_W-1:0] next_o
);

  logic [msr_pkg::PROD_W-1:0] prod_q;
  logic [msr_pkg::PROD_W-1:0] prod_d;
  logic [msr_pkg::SEED_W:0]   fold;

  // Product of the seed and the multiplier, held for the fold cycle.
  assign prod_d = {{msr_pkg::MULT_W{1'b0}}, seed_i} *
                  {{msr_pkg::SEED_W{1'b0}}, msr_pkg::LCG_MULT};

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // Since 2^31 is 1 modulo 2^31 - 1, the high part adds onto the low part.
  // The sum stays below twice the modulus, so one subtract finishes it.
  assign fold = {1'b0, prod_q[msr_pkg::SEED_W-1:0]} +
                {{(msr_pkg::SEED_W + 1 - msr_pkg::MULT_W){1'b0}},
                 prod_q[msr_pkg::PROD_W-1:msr_pkg::SEED_W]};

  always_comb begin
    if (fold >= {1'b0, msr_pkg::LCG_MOD}) begin
      next_o = fold[msr_pkg::SEED_W-1:0] - msr_pkg::LCG_MOD;
    end else begin
      next_o = fold[msr_pkg::SEED_W-1:0];
    end
  end

endmodule

`default_nettype wire

[design/msr_hash_step.sv]
// One-at-a-time hash: the per-byte mix and the closing mix into a seed.
// Depends on msr_pkg for widths and the kept seed width.
`default_nettype none

module msr_hash_step (
  input  wire logic [msr_pkg::HASH_W-1:0] hash_i,
  input  wire logic [7:0]                 byte_i,
  output logic      [msr_pkg::HASH_W-1:0] mixed_o,
  output logic      [msr_pkg::SEED_W-1:0] seed_o
);

  logic [msr_pkg::HASH_W-1:0]      add_b;
  logic [msr_pkg::HASH_W-1:0]      add_s;
  logic [msr_pkg::HASH_W-1:0]      fin_a;
  logic [msr_pkg::HASH_W-1:0]      fin_b;
  logic [msr_pkg::HASH_W-1:0]      fin_c;
  logic [msr_pkg::HASH_KEEP_W-1:0] kept;

  // Per-byte mix; the byte is sign extended before it is added.
  assign add_b   = hash_i + {{(msr_pkg::HASH_W - 8){byte_i[7]}}, byte_i};
  assign add_s   = add_b + (add_b << 10);
  assign mixed_o = add_s ^ (add_s >> 6);

  // Closing mix, then keep the low bits; a zero seed becomes one.
  assign fin_a = hash_i + (hash_i << 3);
  assign fin_b = fin_a ^ (fin_a >> 11);
  assign fin_c = fin_b + (fin_b << 15);
  assign kept  = fin_c[msr_pkg::HASH_KEEP_W-1:0];

  always_comb begin
    if (kept == '0) begin
      seed_o = {{(msr_pkg::SEED_W - 1){1'b0}}, 1'b1};
    end else begin
      seed_o = {{(msr_pkg::SEED_W - msr_pkg::HASH_KEEP_W){1'b0}}, kept};
    end
  end

endmodule

`default_nettype wire
